// ===== hdl/vtp_pkg.sv =====
// Shared types and constants for the vertex transform and projection block.
// No dependencies.
`default_nettype none
package vtp_pkg;

    localparam int COORD_W  = 32;
    localparam int COEF_W   = 16;
    localparam int ROW_W    = 64;
    localparam int SLOPE_W  = 16;
    localparam int PROD_W   = COORD_W + COEF_W;     // one coefficient product
    localparam int ACC_W    = PROD_W + 3;           // row sum with translation and rounding
    localparam int RND_W    = ACC_W - 8;            // row sum after dropping 8 fraction bits
    localparam int PRJ_W    = COORD_W + SLOPE_W + 1;// slope times forward
    localparam int DSUM_W   = PRJ_W + 1;            // divisor with the added one
    localparam int DEN_W    = 48;                   // divisor magnitude
    localparam int FRAC_SH  = 28;
    localparam int NUM_W    = COORD_W + FRAC_SH;    // dividend magnitude
    localparam int QUO_W    = 33;                   // quotient magnitude bits
    localparam int DIV_LAT  = QUO_W + 1;            // range check plus one bit per stage
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_RIGHT   = 3'd0,
        CFG_ROW_FORWARD = 3'd1,
        CFG_ROW_UP      = 3'd2,
        CFG_RIGHT_SLOPE = 3'd3,
        CFG_UP_SLOPE    = 3'd4
    } t_cfg_idx;

    // values carried alongside the dividers
    typedef struct packed {
        logic [COORD_W-1:0] nr;
        logic [COORD_W-1:0] nf;
        logic [COORD_W-1:0] nu;
        logic               sat;
        logic               neg_r;
        logic               neg_u;
        logic               zero_r;
        logic               zero_u;
    } t_side;

    // result, packed as it leaves on the master side
    typedef struct packed {
        logic               fault;
        logic               sat;
        logic [COORD_W-1:0] su;
        logic [COORD_W-1:0] sr;
        logic [COORD_W-1:0] nu;
        logic [COORD_W-1:0] nf;
        logic [COORD_W-1:0] nr;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/vertex_transform_project_top.sv =====
// Vertex transform and projection: affine 3x4 transform, then perspective divide.
// Depends on vtp_pkg and vtp_div.
//
// Usage:
//   Slave stream (i_s_*) takes one vertex per transfer: tdata holds right,
//   forward and up coordinates (signed Q16.16), tuser the position flag.
//   Master stream (o_m_*) returns one result per vertex, in order.
//   Config channel (i_cfg_*) writes the three matrix rows and the two slopes, always ready;
//   the user must write it only while no vertex is in flight; the block has no check.
// Timing:
//   An input transfer reaches o_m_tvalid through five stages of
//   transform and divisor setup (the first loads on the transfer edge), a
//   34-stage divider (range check plus one quotient bit per stage), one result
//   stage and the output register.
//   Throughput is one vertex per cycle while the skid buffer is empty; no item depends on another.
// Reset:
//   Synchronous, active low. Clears all valid bits and reloads the identity
//   matrix and default slopes.
// Back pressure:
//   The output register is backed by a one-entry skid buffer. While the
//   receiver stalls, the pipeline keeps moving until the skid fills; then
//   o_s_tready drops and the whole pipeline holds. Nothing is lost or repeated.
`default_nettype none
module vertex_transform_project_top
    import vtp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [3*COORD_W-1:0]   i_s_tdata,   // coord_right, coord_forward, coord_up
    input  wire logic                   i_s_tuser,   // is_position
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic      [5*COORD_W-1:0]   o_m_tdata,   // new_right, new_forward, new_up,
                                                     // screen_right, screen_up
    output logic      [1:0]             o_m_tuser,   // saturated, divide_fault
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ROW_W-1:0]       i_cfg_data
);

    localparam int FRONT = 5;

    // configuration
    logic [ROW_W-1:0]   r_row [3];
    logic [SLOPE_W-1:0] r_right_slope;
    logic [SLOPE_W-1:0] r_up_slope;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]      <= 64'h0100_0000_0000_0000;
            r_row[1]      <= 64'h0000_0100_0000_0000;
            r_row[2]      <= 64'h0000_0000_0100_0000;
            r_right_slope <= 16'd2868;
            r_up_slope    <= 16'd2868;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_RIGHT:   r_row[0]      <= i_cfg_data;
                CFG_ROW_FORWARD: r_row[1]      <= i_cfg_data;
                CFG_ROW_UP:      r_row[2]      <= i_cfg_data;
                CFG_RIGHT_SLOPE: r_right_slope <= i_cfg_data[SLOPE_W-1:0];
                CFG_UP_SLOPE:    r_up_slope    <= i_cfg_data[SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_sk_valid;
    logic en;
    logic r_vld_front [FRONT];
    logic r_vld_div   [DIV_LAT];
    logic r_vld_f;

    assign en         = !r_sk_valid;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRONT; k++) r_vld_front[k] <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) r_vld_div[k] <= 1'b0;
            r_vld_f <= 1'b0;
        end else if (en) begin
            r_vld_front[0] <= i_s_tvalid;
            for (int k = 1; k < FRONT; k++) r_vld_front[k] <= r_vld_front[k-1];
            r_vld_div[0] <= r_vld_front[FRONT-1];
            for (int k = 1; k < DIV_LAT; k++) r_vld_div[k] <= r_vld_div[k-1];
            r_vld_f <= r_vld_div[DIV_LAT-1];
        end
    end

    // stage 1: coefficient products
    logic signed [COORD_W-1:0] coord [3];
    assign coord[0] = i_s_tdata[COORD_W-1:0];
    assign coord[1] = i_s_tdata[2*COORD_W-1:COORD_W];
    assign coord[2] = i_s_tdata[3*COORD_W-1:2*COORD_W];

    logic signed [PROD_W-1:0] r1_p [3][3];
    logic signed [COEF_W-1:0] r1_t [3];
    logic signed [RND_W-1:0]  r2_s [3];
    logic [COORD_W-1:0]       n3_v [3];
    logic [2:0]               n3_sat;

    for (genvar i = 0; i < 3; i++) begin : g_row
        logic signed [COEF_W-1:0] cf [3];
        logic signed [ACC_W-1:0]  n_acc;
        logic signed [RND_W-1:0]  hi;
        assign cf[0] = r_row[i][63:48];
        assign cf[1] = r_row[i][47:32];
        assign cf[2] = r_row[i][31:16];

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) r1_p[i][k] <= cf[k] * coord[k];
                r1_t[i] <= i_s_tuser ? $signed(r_row[i][15:0]) : '0;
            end
        end

        // stage 2: row sum, round to nearest
        always_comb begin
            n_acc = ACC_W'(r1_p[i][0]) + ACC_W'(r1_p[i][1]) + ACC_W'(r1_p[i][2])
                  + (ACC_W'(r1_t[i]) <<< 16) + ACC_W'(128);
        end
        always_ff @(posedge i_clk) begin
            if (en) r2_s[i] <= RND_W'(n_acc >>> 8);
        end

        // stage 3 logic: clamp to 32 bits
        always_comb begin
            hi = r2_s[i];
            n3_sat[i] = 1'b0;
            n3_v[i]   = hi[COORD_W-1:0];
            if (!hi[RND_W-1] && (|hi[RND_W-2:COORD_W-1])) begin
                n3_sat[i] = 1'b1;
                n3_v[i]   = 32'h7FFF_FFFF;
            end else if (hi[RND_W-1] && !(&hi[RND_W-2:COORD_W-1])) begin
                n3_sat[i] = 1'b1;
                n3_v[i]   = 32'h8000_0000;
            end
        end
    end

    logic [COORD_W-1:0] r3_nr, r3_nf, r3_nu;
    logic               r3_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_nr  <= n3_v[0];
            r3_nf  <= n3_v[1];
            r3_nu  <= n3_v[2];
            r3_sat <= |n3_sat;
        end
    end

    // stage 4: slope times forward
    logic signed [PRJ_W-1:0] r4_pr, r4_pu;
    logic [COORD_W-1:0]      r4_nr, r4_nf, r4_nu;
    logic                    r4_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_pr  <= $signed({1'b0, r_right_slope}) * $signed(r3_nf);
            r4_pu  <= $signed({1'b0, r_up_slope}) * $signed(r3_nf);
            r4_nr  <= r3_nr;
            r4_nf  <= r3_nf;
            r4_nu  <= r3_nu;
            r4_sat <= r3_sat;
        end
    end

    // stage 5: divisor, magnitudes and signs
    logic signed [DSUM_W-1:0] dr, du;
    logic [DSUM_W-1:0]        dr_abs, du_abs;
    logic [COORD_W-1:0]       vr_abs, vu_abs;
    always_comb begin
        dr     = DSUM_W'(r4_pr) + (DSUM_W'(1) <<< FRAC_SH);
        du     = DSUM_W'(r4_pu) + (DSUM_W'(1) <<< FRAC_SH);
        dr_abs = dr[DSUM_W-1] ? DSUM_W'(-dr) : DSUM_W'(dr);
        du_abs = du[DSUM_W-1] ? DSUM_W'(-du) : DSUM_W'(du);
        vr_abs = r4_nr[COORD_W-1] ? COORD_W'(-r4_nr) : r4_nr;
        vu_abs = r4_nu[COORD_W-1] ? COORD_W'(-r4_nu) : r4_nu;
    end

    logic [NUM_W-1:0] r5_num_r, r5_num_u;
    logic [DEN_W-1:0] r5_den_r, r5_den_u;
    t_side            r5_side;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_num_r       <= {vr_abs, {FRAC_SH{1'b0}}};
            r5_num_u       <= {vu_abs, {FRAC_SH{1'b0}}};
            r5_den_r       <= dr_abs[DEN_W-1:0];
            r5_den_u       <= du_abs[DEN_W-1:0];
            r5_side.nr     <= r4_nr;
            r5_side.nf     <= r4_nf;
            r5_side.nu     <= r4_nu;
            r5_side.sat    <= r4_sat;
            r5_side.neg_r  <= r4_nr[COORD_W-1] ^ dr[DSUM_W-1];
            r5_side.neg_u  <= r4_nu[COORD_W-1] ^ du[DSUM_W-1];
            r5_side.zero_r <= (dr == '0);
            r5_side.zero_u <= (du == '0);
        end
    end

    // dividers and matching delay line
    logic [QUO_W-1:0] q_r, q_u;
    logic             ovf_r, ovf_u;

    vtp_div u_div_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num_r),
        .i_den (r5_den_r),
        .o_quo (q_r),
        .o_ovf (ovf_r)
    );

    vtp_div u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num_u),
        .i_den (r5_den_u),
        .o_quo (q_u),
        .o_ovf (ovf_u)
    );

    t_side r_dl [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= r5_side;
            for (int k = 1; k < DIV_LAT; k++) r_dl[k] <= r_dl[k-1];
        end
    end

    // result stage: sign, clamp, zero divisor
    t_side              sd;
    logic [COORD_W-1:0] sr, su;
    logic               sat_r, sat_u;
    t_result            n_res;
    t_result            r_f_res;

    always_comb begin
        sd    = r_dl[DIV_LAT-1];
        sat_r = 1'b0;
        sat_u = 1'b0;
        if (sd.zero_r) begin
            sr = '0;
        end else if (!sd.neg_r && (ovf_r || q_r > 33'h0_7FFF_FFFF)) begin
            sr = 32'h7FFF_FFFF;  sat_r = 1'b1;
        end else if (sd.neg_r && (ovf_r || q_r > 33'h0_8000_0000)) begin
            sr = 32'h8000_0000;  sat_r = 1'b1;
        end else begin
            sr = sd.neg_r ? COORD_W'(-q_r) : q_r[COORD_W-1:0];
        end
        if (sd.zero_u) begin
            su = '0;
        end else if (!sd.neg_u && (ovf_u || q_u > 33'h0_7FFF_FFFF)) begin
            su = 32'h7FFF_FFFF;  sat_u = 1'b1;
        end else if (sd.neg_u && (ovf_u || q_u > 33'h0_8000_0000)) begin
            su = 32'h8000_0000;  sat_u = 1'b1;
        end else begin
            su = sd.neg_u ? COORD_W'(-q_u) : q_u[COORD_W-1:0];
        end
        n_res.nr    = sd.nr;
        n_res.nf    = sd.nf;
        n_res.nu    = sd.nu;
        n_res.sr    = sr;
        n_res.su    = su;
        n_res.sat   = sd.sat | sat_r | sat_u;
        n_res.fault = sd.zero_r | sd.zero_u;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_f_res <= n_res;
    end

    // output register and skid
    logic    r_o_valid;
    t_result r_o_res, r_sk_res;
    logic    pop;

    assign pop = en && r_vld_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (r_o_valid && !i_m_tready) begin
            if (pop) r_sk_valid <= 1'b1;
        end else if (r_sk_valid) begin
            r_o_valid  <= 1'b1;
            r_sk_valid <= 1'b0;
        end else begin
            r_o_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_o_valid && !i_m_tready) begin
            if (pop) r_sk_res <= r_f_res;
        end else if (r_sk_valid) begin
            r_o_res <= r_sk_res;
        end else if (pop) begin
            r_o_res <= r_f_res;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_res.su, r_o_res.sr, r_o_res.nu, r_o_res.nf, r_o_res.nr};
    assign o_m_tuser  = {r_o_res.fault, r_o_res.sat};

endmodule
`default_nettype wire

// ===== hdl/vtp_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on vtp_pkg.
`default_nettype none
module vtp_div
    import vtp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_ovf
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] r_rem   [DIV_LAT];
    logic [DEN_W-1:0] r_den   [DIV_LAT];
    logic [QUO_W-1:0] r_numlo [DIV_LAT];
    logic [QUO_W-1:0] r_quo   [DIV_LAT];
    logic             r_ovf   [DIV_LAT];

    // range check: quotient must fit QUO_W bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_ovf[0]   <= DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den;
            r_numlo[0] <= i_num[QUO_W-1:0];
            r_den[0]   <= i_den;
            r_quo[0]   <= '0;
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
        logic [DEN_W:0] n_trial;
        logic           n_ge;
        always_comb begin
            n_trial = {r_rem[j-1], r_numlo[j-1][QUO_W-1]};
            n_ge    = n_trial >= {1'b0, r_den[j-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]   <= n_ge ? DEN_W'(n_trial - {1'b0, r_den[j-1]})
                                   : n_trial[DEN_W-1:0];
                r_quo[j]   <= {r_quo[j-1][QUO_W-2:0], n_ge};
                r_numlo[j] <= {r_numlo[j-1][QUO_W-2:0], 1'b0};
                r_den[j]   <= r_den[j-1];
                r_ovf[j]   <= r_ovf[j-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule
`default_nettype wire

// ===== hdl/vtp_checker.sv =====
// Port-level checks for vertex_transform_project_top, bound to the top level.
// Depends on vtp_pkg.
`default_nettype none
module vtp_checker
    import vtp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [5*COORD_W-1:0] o_m_tdata,
    input wire logic [1:0]           o_m_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |->
            (o_m_tdata[4*COORD_W-1:3*COORD_W] == '0 ||
             o_m_tdata[5*COORD_W-1:4*COORD_W] == '0))
        else $error("divide fault without a zero screen value");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input stalled without output back pressure");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid full with empty output register");

endmodule

bind vertex_transform_project_top vtp_checker u_vtp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
